// ===== rtl/core/prwt_pkg.sv =====
package prwt_pkg;

    // Default geometry of the ring
    localparam int PAGE_COUNT_DEF    = 64;
    localparam int RECYCLE_TRIES_DEF = 3;

    // Field widths
    localparam int STAMP_W = 64;
    localparam int GUARD_W = 16;
    localparam int FREED_W = 2;
    localparam int FREED_MAX = 3;

    // Guard time scaling: milliseconds to nanoseconds
    localparam int NS_PER_MS = 1000000;
    // 65535 * 1e6 fits in 36 bits
    localparam int LIMIT_W = 36;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/core/prwt_ram.sv =====
module prwt_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/page_ring_writer_timed_recycle_core.sv =====
// Writer side of a ring of pages with timed recycling.
//
// Input transaction: raise start with now_ns (nanosecond timestamp) while
// busy is low; the transaction is taken at that clock edge. Each one writes
// the page at the write index and stamps it with now_ns.
// Result transaction: done pulses high for exactly one cycle with
// slot_index, read_index, pages_freed and used_count. The receiver cannot
// stall, so results never back up.
// Configuration: cfg_wr_en with cfg_wr_data writes the guard time in
// milliseconds; write it only while the block is idle.
//
// Sequence: when the ring is empty or has room, the block goes straight to
// ST_WRITE; when it is nearly full it first tests RECYCLE_TRIES pages in
// ST_TEST (3 by default), one registered read of the stamp memory per tested
// page, then writes the final page in ST_WRITE. busy drops as done rises, so
// no new transaction is taken until the last one's done rises.
// Reset: pointers clear and the ring is empty; a clearing pass then sweeps
// all PAGE_COUNT entries of the page memory, one per cycle, with busy held
// high. Configuration writes are taken during the pass.
module page_ring_writer_timed_recycle_core #(
    parameter int PAGE_COUNT    = prwt_pkg::PAGE_COUNT_DEF,
    parameter int RECYCLE_TRIES = prwt_pkg::RECYCLE_TRIES_DEF,
    localparam int IdxW = $clog2(PAGE_COUNT),
    localparam int CntW = $clog2(PAGE_COUNT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [prwt_pkg::STAMP_W-1:0]  now_ns,
    input  logic                          cfg_wr_en,
    input  logic [prwt_pkg::GUARD_W-1:0]  cfg_wr_data,
    output logic                          done,
    output logic [IdxW-1:0]               slot_index,
    output logic [IdxW-1:0]               read_index,
    output logic [prwt_pkg::FREED_W-1:0]  pages_freed,
    output logic [CntW-1:0]               used_count
);

    localparam int StampW    = prwt_pkg::STAMP_W;
    localparam int MemW      = StampW + 1;
    localparam int LimitW    = prwt_pkg::LIMIT_W;
    localparam int TryW      = $clog2(RECYCLE_TRIES + 1);
    localparam int FreeLimit = PAGE_COUNT - RECYCLE_TRIES;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(PAGE_COUNT - 1);

    // Step an index around the ring
    function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] v);
        next_idx = (v == LastIdx) ? '0 : v + 1'b1;
    endfunction

    // Pages held between read and write pointers; equal pointers mean full unless empty is set
    function automatic logic [CntW-1:0] held_pages(
        input logic [IdxW-1:0] wr,
        input logic [IdxW-1:0] rd,
        input logic            empty
    );
        logic [CntW-1:0] diff;
        diff = CntW'(wr) - CntW'(rd);
        if (wr < rd)
        begin
            diff = diff + CntW'(PAGE_COUNT);
        end
        if (empty)
        begin
            held_pages = '0;
        end
        else if (diff == '0)
        begin
            held_pages = CntW'(PAGE_COUNT);
        end
        else
        begin
            held_pages = diff;
        end
    endfunction

    prwt_pkg::state_t state_reg, state_next;

    logic [IdxW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic              empty_reg, empty_next;
    logic              full_reg, full_next;
    logic [prwt_pkg::GUARD_W-1:0] guard_reg;
    logic [LimitW-1:0] limit_reg, limit_next;
    logic [StampW-1:0] now_reg, now_next;
    logic [IdxW-1:0]   test_idx_reg, test_idx_next;
    logic [TryW-1:0]   try_reg, try_next;
    logic [TryW-1:0]   freed_reg, freed_next;
    logic [IdxW-1:0]   clr_reg, clr_next;
    logic              done_reg, done_next;

    logic [IdxW-1:0]   windex_reg, windex_next;
    logic [IdxW-1:0]   rindex_reg, rindex_next;
    logic [prwt_pkg::FREED_W-1:0] pfreed_reg, pfreed_next;
    logic [CntW-1:0]   used_reg, used_next;

    // Page memory: valid bit on top of the stamp
    logic              mem_wr_en;
    logic [IdxW-1:0]   mem_wr_addr;
    logic [MemW-1:0]   mem_wr_data;
    logic              mem_rd_en;
    logic [IdxW-1:0]   mem_rd_addr;
    logic [MemW-1:0]   mem_rd_data;

    logic              accept;
    logic [CntW-1:0]   held_now;
    logic              page_ok;
    logic [StampW-1:0] page_age;
    logic              expired;
    logic              forced;

    prwt_ram #(
        .WIDTH (MemW),
        .DEPTH (PAGE_COUNT)
    ) u_page_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign busy   = (state_reg != prwt_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign held_now = held_pages(wr_ptr_reg, rd_ptr_reg, empty_reg);

    // Page test on the word read back from memory
    assign page_ok  = mem_rd_data[StampW];
    assign page_age = now_reg - mem_rd_data[StampW-1:0];
    assign expired  = page_age > StampW'(limit_reg);
    assign forced   = full_reg && (test_idx_reg == wr_ptr_reg);

    always_comb
    begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        empty_next    = empty_reg;
        full_next     = full_reg;
        limit_next    = limit_reg;
        now_next      = now_reg;
        test_idx_next = test_idx_reg;
        try_next      = try_reg;
        freed_next    = freed_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        windex_next   = windex_reg;
        rindex_next   = rindex_reg;
        pfreed_next   = pfreed_reg;
        used_next     = used_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = wr_ptr_reg;
        mem_wr_data   = {1'b1, now_reg};
        mem_rd_en     = 1'b0;
        mem_rd_addr   = wr_ptr_reg;

        case (state_reg)
            prwt_pkg::ST_CLEAR:
            begin
                // Sweep the memory and drop every valid bit
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = next_idx(clr_reg);
                if (clr_reg == LastIdx)
                begin
                    state_next = prwt_pkg::ST_IDLE;
                end
            end

            prwt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    now_next   = now_ns;
                    limit_next = LimitW'(guard_reg) * LimitW'(prwt_pkg::NS_PER_MS);
                    full_next  = !empty_reg && (wr_ptr_reg == rd_ptr_reg);
                    freed_next = '0;
                    if (empty_reg)
                    begin
                        rd_ptr_next = '0;
                        empty_next  = 1'b0;
                        state_next  = prwt_pkg::ST_WRITE;
                    end
                    else if (int'(held_now) > FreeLimit)
                    begin
                        // Fetch the first page to test
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = wr_ptr_reg;
                        test_idx_next = wr_ptr_reg;
                        try_next      = '0;
                        state_next    = prwt_pkg::ST_TEST;
                    end
                    else
                    begin
                        state_next = prwt_pkg::ST_WRITE;
                    end
                end
            end

            prwt_pkg::ST_TEST:
            begin
                if (page_ok && (expired || forced))
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = test_idx_reg;
                    mem_wr_data = {1'b0, now_reg};
                    rd_ptr_next = next_idx(rd_ptr_reg);
                    freed_next  = freed_reg + 1'b1;
                end
                if (int'(try_reg) == RECYCLE_TRIES - 1)
                begin
                    state_next = prwt_pkg::ST_WRITE;
                end
                else
                begin
                    // Overlap the next fetch with this write back
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = next_idx(test_idx_reg);
                    test_idx_next = next_idx(test_idx_reg);
                    try_next      = try_reg + 1'b1;
                end
            end

            prwt_pkg::ST_WRITE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = wr_ptr_reg;
                mem_wr_data = {1'b1, now_reg};
                wr_ptr_next = next_idx(wr_ptr_reg);
                windex_next = wr_ptr_reg;
                rindex_next = rd_ptr_reg;
                pfreed_next = (int'(freed_reg) > prwt_pkg::FREED_MAX)
                            ? prwt_pkg::FREED_W'(prwt_pkg::FREED_MAX)
                            : prwt_pkg::FREED_W'(freed_reg);
                used_next   = held_pages(next_idx(wr_ptr_reg), rd_ptr_reg, 1'b0);
                done_next   = 1'b1;
                state_next  = prwt_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = prwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prwt_pkg::ST_CLEAR;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            empty_reg <= 1'b1;
            full_reg <= 1'b0;
            guard_reg <= '0;
            try_reg <= '0;
            freed_reg <= '0;
            clr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            empty_reg <= empty_next;
            full_reg <= full_next;
            try_reg <= try_next;
            freed_reg <= freed_next;
            clr_reg <= clr_next;
            done_reg <= done_next;
            if (cfg_wr_en)
            begin
                guard_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
        now_reg <= now_next;
        test_idx_reg <= test_idx_next;
        windex_reg <= windex_next;
        rindex_reg <= rindex_next;
        pfreed_reg <= pfreed_next;
        used_reg <= used_next;
    end

    assign done        = done_reg;
    assign slot_index  = windex_reg;
    assign read_index  = rindex_reg;
    assign pages_freed = pfreed_reg;
    assign used_count  = used_reg;

endmodule

// ===== rtl/core/prwt_checker.sv =====
module prwt_checker #(
    parameter int PAGE_COUNT = prwt_pkg::PAGE_COUNT_DEF,
    localparam int IdxW = $clog2(PAGE_COUNT),
    localparam int CntW = $clog2(PAGE_COUNT + 1)
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [IdxW-1:0]              slot_index,
    input logic [IdxW-1:0]              read_index,
    input logic [CntW-1:0]              used_count
);

    // A taken transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted transaction");

    // A result shows while idle and only after a busy cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a transaction");

    // The strobe lasts exactly one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // The page just written is held, so the ring is never empty after a write
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((used_count != '0) && (int'(used_count) <= PAGE_COUNT)))
        else $error("used count out of range");

    // A full ring leaves the write index one behind the read index
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (int'(used_count) == PAGE_COUNT)) |->
            ((int'(slot_index) == PAGE_COUNT - 1) ? (read_index == '0)
                : (read_index == slot_index + 1'b1)))
        else $error("full ring with inconsistent indexes");

endmodule

bind page_ring_writer_timed_recycle_core prwt_checker #(
    .PAGE_COUNT (PAGE_COUNT)
) u_prwt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .slot_index  (slot_index),
    .read_index  (read_index),
    .used_count  (used_count)
);
